@@ hw/rtl/wfsa_pkg.sv @@
// wfsa_pkg: shared types and constants for the worst-fit segment allocator
// no dependencies

package wfsa_pkg;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [1:0] STATUS_NOT_ALLOC = 2'd2;
    localparam logic [1:0] STATUS_FULL     = 2'd3;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // largest managed memory, in cells
    localparam logic [16:0] MEM_CELLS = 17'h10000;

    typedef struct packed {
        logic kind;
        logic [16:0] alloc_size;
        logic [15:0] block_start;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [15:0] position;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic init;        // reload table with one free segment
        logic load_req;    // capture request, clear scan state
        logic scan_rd;     // read entry at scan index and advance
        logic decide;      // latch outcome of scan
        logic shift_step;  // one step of the shift pass
        logic fix_step;    // one fixup write
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;   // scan index at last entry
        logic shift_done;  // shift pass complete
        logic fix_any;     // a fixup write is pending
        logic fix_last;    // pending fixup write is the last one
    } sts_t;

endpackage

@@ hw/rtl/wfsa_if.sv @@
// wfsa_if: valid/ready channel carrying one payload
// depends on nothing; payload type chosen by parameter

interface wfsa_if #(
    parameter type payload_t = logic
);
    logic valid;
    logic ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/worst_fit_segment_allocator.sv @@
// worst_fit_segment_allocator: top level, joins controller and datapath
// depends on wfsa_pkg, wfsa_if, wfsa_ctrl, wfsa_dp
//
// channel  dir  payload
// req      in   kind, alloc_size, block_start
// rsp      out  status, position
// cfg      in   cfg_we, cfg_wdata (cell count)
//
// an item reads the N-entry table one entry per cycle, decides, moves the entries
// that shift and then makes its fixup writes; the segment table has one read port
// and one write port
// reset or a cfg write leaves one free segment over the whole memory
// a result holds until taken; no new item enters meanwhile

module worst_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [16:0] cfg_wdata,
    wfsa_if.sink req,
    wfsa_if.source rsp
);
    import wfsa_pkg::*;

    logic [16:0] size_reg;
    cmd_t cmd;
    sts_t sts;
    rsp_t rsp_d;
    req_t req_d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= MEM_CELLS;
        else if (cfg_we)
            size_reg <= (cfg_wdata == '0) ? 17'd1 :
                        (cfg_wdata > MEM_CELLS) ? MEM_CELLS : cfg_wdata;
    end

    assign req_d = req.payload;

    wfsa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we),
        .in_valid(req.valid), .in_ready(req.ready),
        .out_valid(rsp.valid), .out_ready(rsp.ready),
        .cmd(cmd), .sts(sts)
    );

    wfsa_dp #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .mem_size(size_reg), .req(req_d),
        .cmd(cmd), .sts(sts), .rsp(rsp_d)
    );

    assign rsp.payload = rsp_d;

endmodule

@@ hw/rtl/wfsa_ctrl.sv @@
// wfsa_ctrl: sequencer for scan, shift and fixup phases
// depends on wfsa_pkg

module wfsa_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output wfsa_pkg::cmd_t cmd,
    input  wfsa_pkg::sts_t sts
);
    import wfsa_pkg::*;

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_SHIFT  = 3'd5;
    localparam logic [2:0] S_FIX    = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        if (cfg_we)
        begin
            // table reload starts in S_INIT, after the new size is registered
            state_next = S_INIT;
        end
        else
        begin
            unique case (state_reg)
                S_INIT:
                begin
                    cmd.init = 1'b1;
                    state_next = S_IDLE;
                end
                S_IDLE:
                begin
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        cmd.load_req = 1'b1;
                        state_next = S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    cmd.scan_rd = 1'b1;
                    if (sts.scan_last)
                        state_next = S_DRAIN;
                end
                S_DRAIN:
                begin
                    // last read is evaluated here
                    state_next = S_DECIDE;
                end
                S_DECIDE:
                begin
                    cmd.decide = 1'b1;
                    state_next = S_SHIFT;
                end
                S_SHIFT:
                begin
                    cmd.shift_step = 1'b1;
                    if (sts.shift_done)
                        state_next = sts.fix_any ? S_FIX : S_OUT;
                end
                S_FIX:
                begin
                    cmd.fix_step = 1'b1;
                    if (sts.fix_last)
                        state_next = S_OUT;
                end
                S_OUT:
                begin
                    out_valid = 1'b1;
                    if (out_ready)
                        state_next = S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/wfsa_dp.sv @@
// wfsa_dp: segment table memory, scan, shift and fixup datapath
// depends on wfsa_pkg

module wfsa_dp #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic [16:0] mem_size,
    input  wfsa_pkg::req_t req,
    input  wfsa_pkg::cmd_t cmd,
    output wfsa_pkg::sts_t sts,
    output wfsa_pkg::rsp_t rsp
);
    import wfsa_pkg::*;

    localparam int ADDR_W = 16;
    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = IDX_W + 1;

    // one packed entry: start, end, free
    localparam int ENT_W = 2 * ADDR_W + 2;
    logic [ENT_W-1:0] mem [MAX_SEGMENTS];
    logic [ENT_W-1:0] rd_data_reg;
    logic rd_en;
    logic wr_en;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;

    logic [CNT_W-1:0] count_reg;
    req_t req_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic ev_valid_reg;
    logic [IDX_W-1:0] ev_idx_reg;
    // allocate scan
    logic found_reg;
    logic [IDX_W-1:0] best_reg;
    logic [ADDR_W:0] best_len_reg;
    logic [ENT_W-1:0] best_ent_reg;
    // free scan
    logic hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [ENT_W-1:0] hit_ent_reg;
    logic [ENT_W-1:0] prev_ent_reg;  // entry before the hit
    logic [ENT_W-1:0] next_ent_reg;  // entry after the hit
    logic [ENT_W-1:0] last_ent_reg;  // last evaluated entry
    logic have_next_reg;
    // outcome
    logic [1:0] status_reg;
    logic [ADDR_W-1:0] pos_reg;
    // shift pass: copy sh_left entries starting at sh_src
    logic sh_up_reg;                 // 1: open a hole, 0: close one
    logic sh_two_reg;                // close a hole of two entries
    logic sh_pend_reg;               // read data waits to be written
    logic [CNT_W-1:0] sh_src_reg;
    logic [CNT_W-1:0] sh_left_reg;
    logic [IDX_W-1:0] sh_dst_reg;
    // fixup writes after the shift
    logic fix0_en_reg, fix1_en_reg;
    logic [IDX_W-1:0] fix0_addr_reg, fix1_addr_reg;
    logic [ENT_W-1:0] fix0_data_reg, fix1_data_reg;

    logic [ADDR_W:0] ev_len;
    logic ev_hit;
    logic [ADDR_W:0] split_at;
    logic no_space;
    logic prev_free, next_free;
    logic [CNT_W-1:0] hit_cnt;
    logic [CNT_W-1:0] sh_dst;

    logic [1:0] dec_status;
    logic [ADDR_W-1:0] dec_pos;
    logic [CNT_W-1:0] dec_count, dec_sh_src, dec_sh_left;
    logic dec_sh_up, dec_sh_two;
    logic dec_fix0_en, dec_fix1_en;
    logic [IDX_W-1:0] dec_fix0_addr, dec_fix1_addr;
    logic [ENT_W-1:0] dec_fix0_data, dec_fix1_data;

    function automatic logic [ADDR_W-1:0] e_start(input logic [ENT_W-1:0] e);
        e_start = e[ENT_W-1 -: ADDR_W];
    endfunction
    function automatic logic [ADDR_W:0] e_end(input logic [ENT_W-1:0] e);
        e_end = e[ADDR_W+1:1];
    endfunction
    function automatic logic e_free(input logic [ENT_W-1:0] e);
        e_free = e[0];
    endfunction

    assign ev_len = e_end(rd_data_reg) - {1'b0, e_start(rd_data_reg)};
    assign ev_hit = !e_free(rd_data_reg) && (e_start(rd_data_reg) == req_reg.block_start);

    // first cell of the free remainder after a split
    assign split_at = {1'b0, e_start(best_ent_reg)} + req_reg.alloc_size;
    assign no_space = (req_reg.alloc_size == '0) || !found_reg ||
                      (req_reg.alloc_size > best_len_reg);
    assign prev_free = (hit_idx_reg != '0) && e_free(prev_ent_reg);
    assign next_free = have_next_reg && e_free(next_ent_reg);
    assign hit_cnt = {1'b0, hit_idx_reg};

    assign sh_dst = sh_up_reg ? (sh_src_reg + CNT_W'(1)) :
                    (sh_src_reg - (sh_two_reg ? CNT_W'(2) : CNT_W'(1)));

    always_comb
    begin
        rd_en = 1'b0;
        rd_addr = '0;
        if (cmd.scan_rd)
        begin
            rd_en = 1'b1;
            rd_addr = rd_idx_reg[IDX_W-1:0];
        end
        else if (cmd.shift_step && sh_left_reg != '0)
        begin
            rd_en = 1'b1;
            rd_addr = sh_src_reg[IDX_W-1:0];
        end
    end

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (cmd.init)
        begin
            wr_en = 1'b1;
            wr_data = {{ADDR_W{1'b0}}, mem_size, 1'b1};
        end
        else if (cmd.shift_step && sh_pend_reg)
        begin
            wr_en = 1'b1;
            wr_addr = sh_dst_reg;
            wr_data = rd_data_reg;
        end
        else if (cmd.fix_step)
        begin
            wr_en = 1'b1;
            wr_addr = fix0_addr_reg;
            wr_data = fix0_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    assign sts = '{scan_last: ((rd_idx_reg + CNT_W'(1)) >= count_reg),
                   shift_done: ((sh_left_reg == '0) && !sh_pend_reg),
                   fix_any: fix0_en_reg,
                   fix_last: !fix1_en_reg};

    assign rsp = '{status: status_reg, position: pos_reg};

    // outcome of the scan
    always_comb
    begin
        dec_status = STATUS_OK;
        dec_pos = '0;
        dec_count = count_reg;
        dec_sh_src = '0;
        dec_sh_left = '0;
        dec_sh_up = 1'b0;
        dec_sh_two = 1'b0;
        dec_fix0_en = 1'b0;
        dec_fix1_en = 1'b0;
        dec_fix0_addr = '0;
        dec_fix1_addr = '0;
        dec_fix0_data = '0;
        dec_fix1_data = '0;
        if (req_reg.kind == KIND_ALLOC)
        begin
            if (no_space)
                dec_status = STATUS_NO_SPACE;
            else if (req_reg.alloc_size == best_len_reg)
            begin
                dec_pos = e_start(best_ent_reg);
                dec_fix0_en = 1'b1;
                dec_fix0_addr = best_reg;
                dec_fix0_data = {best_ent_reg[ENT_W-1:1], 1'b0};
            end
            else if (count_reg >= CNT_W'(MAX_SEGMENTS))
                dec_status = STATUS_FULL;
            else
            begin
                dec_pos = e_start(best_ent_reg);
                // entries above best move up by one, top first
                dec_sh_up = 1'b1;
                dec_sh_src = count_reg - CNT_W'(1);
                dec_sh_left = count_reg - CNT_W'(1) - {1'b0, best_reg};
                dec_count = count_reg + CNT_W'(1);
                dec_fix0_en = 1'b1;
                dec_fix0_addr = best_reg;
                dec_fix0_data = {e_start(best_ent_reg), split_at, 1'b0};
                dec_fix1_en = 1'b1;
                dec_fix1_addr = best_reg + IDX_W'(1);
                dec_fix1_data = {split_at[ADDR_W-1:0], e_end(best_ent_reg), 1'b1};
            end
        end
        else if (!hit_reg)
            dec_status = STATUS_NOT_ALLOC;
        else
        begin
            dec_fix0_en = 1'b1;
            if (prev_free && next_free)
            begin
                // previous entry absorbs the block and the next entry
                dec_sh_two = 1'b1;
                dec_sh_src = hit_cnt + CNT_W'(2);
                dec_sh_left = count_reg - hit_cnt - CNT_W'(2);
                dec_count = count_reg - CNT_W'(2);
                dec_fix0_addr = hit_idx_reg - IDX_W'(1);
                dec_fix0_data = {e_start(prev_ent_reg), e_end(next_ent_reg), 1'b1};
            end
            else if (next_free)
            begin
                dec_sh_src = hit_cnt + CNT_W'(2);
                dec_sh_left = count_reg - hit_cnt - CNT_W'(2);
                dec_count = count_reg - CNT_W'(1);
                dec_fix0_addr = hit_idx_reg;
                dec_fix0_data = {e_start(hit_ent_reg), e_end(next_ent_reg), 1'b1};
            end
            else if (prev_free)
            begin
                dec_sh_src = hit_cnt + CNT_W'(1);
                dec_sh_left = count_reg - hit_cnt - CNT_W'(1);
                dec_count = count_reg - CNT_W'(1);
                dec_fix0_addr = hit_idx_reg - IDX_W'(1);
                dec_fix0_data = {e_start(prev_ent_reg), e_end(hit_ent_reg), 1'b1};
            end
            else
            begin
                dec_fix0_addr = hit_idx_reg;
                dec_fix0_data = {hit_ent_reg[ENT_W-1:1], 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_W'(1);
            req_reg <= '0;
            rd_idx_reg <= '0;
            ev_valid_reg <= 1'b0;
            ev_idx_reg <= '0;
            found_reg <= 1'b0;
            best_reg <= '0;
            best_len_reg <= '0;
            best_ent_reg <= '0;
            hit_reg <= 1'b0;
            hit_idx_reg <= '0;
            hit_ent_reg <= '0;
            prev_ent_reg <= '0;
            next_ent_reg <= '0;
            last_ent_reg <= '0;
            have_next_reg <= 1'b0;
            status_reg <= STATUS_OK;
            pos_reg <= '0;
            sh_up_reg <= 1'b0;
            sh_two_reg <= 1'b0;
            sh_pend_reg <= 1'b0;
            sh_src_reg <= '0;
            sh_left_reg <= '0;
            sh_dst_reg <= '0;
            fix0_en_reg <= 1'b0;
            fix1_en_reg <= 1'b0;
            fix0_addr_reg <= '0;
            fix1_addr_reg <= '0;
            fix0_data_reg <= '0;
            fix1_data_reg <= '0;
        end
        else
        begin
            // read data is evaluated in the cycle after the scan read
            ev_valid_reg <= cmd.scan_rd;
            ev_idx_reg <= rd_idx_reg[IDX_W-1:0];
            if (cmd.init)
                count_reg <= CNT_W'(1);
            if (cmd.load_req)
            begin
                req_reg <= req;
                rd_idx_reg <= '0;
                found_reg <= 1'b0;
                best_len_reg <= '0;
                hit_reg <= 1'b0;
                have_next_reg <= 1'b0;
            end
            if (cmd.scan_rd)
                rd_idx_reg <= rd_idx_reg + CNT_W'(1);
            if (ev_valid_reg)
            begin
                if (req_reg.kind == KIND_ALLOC)
                begin
                    // strictly larger keeps the leftmost on a tie
                    if (e_free(rd_data_reg) && (!found_reg || ev_len > best_len_reg))
                    begin
                        found_reg <= 1'b1;
                        best_reg <= ev_idx_reg;
                        best_len_reg <= ev_len;
                        best_ent_reg <= rd_data_reg;
                    end
                end
                else if (!hit_reg && ev_hit)
                begin
                    hit_reg <= 1'b1;
                    hit_idx_reg <= ev_idx_reg;
                    hit_ent_reg <= rd_data_reg;
                    prev_ent_reg <= last_ent_reg;
                end
                else if (hit_reg && !have_next_reg)
                begin
                    have_next_reg <= 1'b1;
                    next_ent_reg <= rd_data_reg;
                end
                last_ent_reg <= rd_data_reg;
            end
            if (cmd.decide)
            begin
                status_reg <= dec_status;
                pos_reg <= dec_pos;
                count_reg <= dec_count;
                sh_up_reg <= dec_sh_up;
                sh_two_reg <= dec_sh_two;
                sh_src_reg <= dec_sh_src;
                sh_left_reg <= dec_sh_left;
                sh_pend_reg <= 1'b0;
                fix0_en_reg <= dec_fix0_en;
                fix0_addr_reg <= dec_fix0_addr;
                fix0_data_reg <= dec_fix0_data;
                fix1_en_reg <= dec_fix1_en;
                fix1_addr_reg <= dec_fix1_addr;
                fix1_data_reg <= dec_fix1_data;
            end
            if (cmd.shift_step)
            begin
                // read source now, write it to its destination next cycle
                sh_pend_reg <= (sh_left_reg != '0);
                if (sh_left_reg != '0)
                begin
                    sh_dst_reg <= sh_dst[IDX_W-1:0];
                    sh_src_reg <= sh_up_reg ? (sh_src_reg - CNT_W'(1)) :
                                  (sh_src_reg + CNT_W'(1));
                    sh_left_reg <= sh_left_reg - CNT_W'(1);
                end
            end
            if (cmd.fix_step)
            begin
                fix0_en_reg <= fix1_en_reg;
                fix0_addr_reg <= fix1_addr_reg;
                fix0_data_reg <= fix1_data_reg;
                fix1_en_reg <= 1'b0;
            end
        end
    end

endmodule

@@ verif/tb_worst_fit_segment_allocator.sv @@
// testbench for worst_fit_segment_allocator: drives allocate/free requests, predicts
// every response with a local segment-table model held in a scoreboard class
// depends on wfsa_pkg, wfsa_if and the allocator rtl
`timescale 1ns / 1ps

module tb_worst_fit_segment_allocator;
    import wfsa_pkg::*;

    localparam int NSEG = 64;
    localparam int LIMIT_CELLS = 65536;

    class alloc_scoreboard;
        int unsigned seg_lo[NSEG];
        int unsigned seg_hi[NSEG];
        bit seg_free[NSEG];
        int unsigned seg_cnt;
        int unsigned mem_cells;
        rsp_t pending[$];
        int errors;
        // allocated block starts, used by the stimulus to pick valid frees
        int unsigned live[$];

        function void set_size(int unsigned v);
            v = v & 17'h1ffff;
            if (v == 0) v = 1;
            if (v > LIMIT_CELLS) v = LIMIT_CELLS;
            mem_cells = v;
            seg_cnt = 1;
            seg_lo[0] = 0;
            seg_hi[0] = v;
            seg_free[0] = 1;
            live.delete();
        endfunction

        function void drop_entry(int unsigned i);
            for (int unsigned k = i; k + 1 < seg_cnt; k++) begin
                seg_lo[k] = seg_lo[k+1];
                seg_hi[k] = seg_hi[k+1];
                seg_free[k] = seg_free[k+1];
            end
            seg_cnt--;
        endfunction

        function rsp_t predict_alloc(int unsigned want);
            rsp_t r;
            int unsigned best, best_len, len, at;
            bit found;
            r.status = STATUS_OK;
            r.position = '0;
            best = 0;
            best_len = 0;
            found = 0;
            for (int unsigned i = 0; i < seg_cnt; i++) begin
                len = seg_hi[i] - seg_lo[i];
                if (seg_free[i] && (!found || len > best_len)) begin
                    found = 1;
                    best = i;
                    best_len = len;
                end
            end
            if (want == 0 || !found || best_len < want) begin
                r.status = STATUS_NO_SPACE;
                return r;
            end
            at = seg_lo[best];
            if (best_len == want) begin
                seg_free[best] = 0;
            end else if (seg_cnt >= NSEG) begin
                r.status = STATUS_FULL;
                return r;
            end else begin
                for (int unsigned k = seg_cnt; k > best; k--) begin
                    seg_lo[k] = seg_lo[k-1];
                    seg_hi[k] = seg_hi[k-1];
                    seg_free[k] = seg_free[k-1];
                end
                seg_cnt++;
                seg_hi[best] = at + want;
                seg_free[best] = 0;
                seg_lo[best+1] = at + want;
            end
            live = {live, at};
            r.position = at[15:0];
            return r;
        endfunction

        function rsp_t predict_free(int unsigned addr);
            rsp_t r;
            int unsigned idx;
            bit found;
            int hits[$];
            r.status = STATUS_OK;
            r.position = '0;
            found = 0;
            idx = 0;
            for (int unsigned i = 0; i < seg_cnt; i++) begin
                if (!found && !seg_free[i] && seg_lo[i] == addr) begin
                    idx = i;
                    found = 1;
                end
            end
            if (!found) begin
                r.status = STATUS_NOT_ALLOC;
                return r;
            end
            hits = live.find_first_index(x) with (x == addr);
            if (hits.size() != 0)
                live.delete(hits[0]);
            seg_free[idx] = 1;
            if (idx + 1 < seg_cnt && seg_free[idx+1]) begin
                seg_hi[idx] = seg_hi[idx+1];
                drop_entry(idx + 1);
            end
            if (idx > 0 && seg_free[idx-1]) begin
                seg_hi[idx-1] = seg_hi[idx];
                drop_entry(idx);
            end
            return r;
        endfunction

        function void note_request(req_t q);
            if (q.kind == KIND_ALLOC)
                pending = {pending, predict_alloc(q.alloc_size)};
            else
                pending = {pending, predict_free(q.block_start)};
        endfunction

        function void check_response(rsp_t got);
            rsp_t exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected response status=%0d position=%0d",
                         $time, got.status, got.position);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.status !== exp_r.status) begin
                $display("%0t: status mismatch expected %0d actual %0d",
                         $time, exp_r.status, got.status);
                errors++;
            end
            if (got.position !== exp_r.position) begin
                $display("%0t: position mismatch expected %0d actual %0d",
                         $time, exp_r.position, got.position);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [16:0] cfg_wdata = '0;
    bit rx_hold = 0;
    bit rx_long = 0;
    int unsigned cur_cells;

    wfsa_if #(.payload_t(req_t)) req_ch ();
    wfsa_if #(.payload_t(rsp_t)) rsp_ch ();

    alloc_scoreboard sb;

    worst_fit_segment_allocator i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .req(req_ch.sink),
        .rsp(rsp_ch.source)
    );

    always #4 clk = ~clk;

    initial
    begin
        req_ch.valid = 0;
        req_ch.payload = '0;
        rsp_ch.ready = 0;
    end

    // receiver: stall pattern plus one long hold-off
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.payload);
        if (rx_long)
            rsp_ch.ready <= 0;
        else if (rx_hold)
            rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        else
            rsp_ch.ready <= 1;
    end

    initial
    begin
        forever
        begin
            repeat ($urandom_range(100, 400)) @(posedge clk);
            rx_hold = ~rx_hold;
        end
    end

    task automatic send_request(req_t q);
        // sender gap before some transfers
        if ($urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_ch.valid <= 1;
        req_ch.payload <= q;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sb.note_request(q);
    endtask

    task automatic drain();
        req_ch.valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (3 * NSEG + 10) @(posedge clk);
    endtask

    task automatic write_size(int unsigned v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= v[16:0];
        @(posedge clk);
        cfg_we <= 0;
        sb.set_size(v);
        cur_cells = sb.mem_cells;
        @(posedge clk);
    endtask

    function automatic req_t make_alloc(int unsigned n);
        req_t q;
        q = '0;
        q.kind = KIND_ALLOC;
        q.alloc_size = n[16:0];
        q.block_start = 16'($urandom);
        return q;
    endfunction

    function automatic req_t make_free(int unsigned a);
        req_t q;
        q = '0;
        q.kind = KIND_FREE;
        q.block_start = a[15:0];
        q.alloc_size = 17'($urandom);
        return q;
    endfunction

    function automatic req_t random_request();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            if ($urandom_range(0, 9) == 0)
                return make_alloc($urandom_range(0, 17'h1ffff));
            return make_alloc($urandom_range(1, (cur_cells / 16) + 1));
        end
        if (pick < 90 && sb.live.size() != 0)
            return make_free(sb.live[$urandom_range(0, sb.live.size() - 1)]);
        return make_free($urandom_range(0, 16'hffff));
    endfunction

    initial
    begin
        int unsigned sizes[6];
        sb = new();
        sb.errors = 0;
        sb.set_size(65536);
        cur_cells = 65536;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, exact fit, merges, unknown block, zero size
        send_request(make_alloc(0));
        send_request(make_alloc(17'h1ffff));
        send_request(make_alloc(65537));
        send_request(make_alloc(1));
        send_request(make_alloc(100));
        send_request(make_free(1));
        send_request(make_free(0));
        send_request(make_free(0));
        send_request(make_alloc(65536));
        send_request(make_alloc(1));
        send_request(make_free(0));
        send_request(make_free(16'hffff));
        send_request(make_alloc(32768));
        send_request(make_alloc(32768));
        send_request(make_free(32768));
        send_request(make_free(0));
        // fill table until it reports full
        for (int i = 0; i < 66; i++)
            send_request(make_alloc(1));

        sizes = '{1, 0, 2, 17'h1ffff, 100, 5000};
        foreach (sizes[s])
        begin
            write_size(sizes[s]);
            send_request(make_alloc(1));
            send_request(make_alloc(2));
            send_request(make_free(0));
            for (int i = 0; i < 160; i++)
            begin
                if (s == 2 && i == 20)
                begin
                    // long hold-off with the sender still pushing
                    rx_long = 1;
                    fork
                        begin
                            repeat (600) @(posedge clk);
                            rx_long = 0;
                        end
                    join_none
                end
                send_request(random_request());
            end
        end
        write_size(65536);
        for (int i = 0; i < 40; i++)
            send_request(random_request());

        drain();
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
